>>> rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int CAPACITY   = 256;
	localparam int VALUE_BITS = 32;
	localparam int COUNT_BITS = $clog2(CAPACITY + 1);

	// operation codes
	localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
	localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
	localparam logic [1:0] OP_POP_FRONT  = 2'd2;
	localparam logic [1:0] OP_POP_BACK   = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// per-cycle move of a cell chain
	typedef logic [1:0] cell_mode_t;
	localparam cell_mode_t MODE_HOLD   = 2'd0;
	localparam cell_mode_t MODE_INSERT = 2'd1; // shift toward the tail, new value at head
	localparam cell_mode_t MODE_REMOVE = 2'd2; // shift toward the head, head drops out
	localparam cell_mode_t MODE_APPEND = 2'd3; // write new value just past the last entry

	typedef logic [VALUE_BITS-1:0] value_t;

	typedef struct packed {
		cell_mode_t mode;
		value_t     value;
	} chain_req_t;

endpackage

>>> rtl/deq_cell.sv
// ----------------------------------------------------------------------------
// deq_cell
// One storage cell of a chain: holds one entry and trades it with neighbors.
// ----------------------------------------------------------------------------
module deq_cell
	import deq_pkg::*;
(
	input  logic       clk,
	input  chain_req_t req,
	input  logic       at_tail,   // this cell is the first free slot
	input  value_t     left_val,  // neighbor nearer the head (or new value at head)
	input  value_t     right_val, // neighbor nearer the tail
	output value_t     val
);

	value_t val_q;

	always_ff @(posedge clk) begin
		case (req.mode)
			MODE_INSERT: val_q <= left_val;
			MODE_REMOVE: val_q <= right_val;
			MODE_APPEND: begin
				if (at_tail) begin
					val_q <= req.value;
				end
			end
			default: val_q <= val_q;
		endcase
	end

	assign val = val_q;

endmodule

>>> rtl/deq_chain.sv
// ----------------------------------------------------------------------------
// deq_chain
// Row of cells with its head at cell 0; entries occupy cells 0 to count-1.
// ----------------------------------------------------------------------------
module deq_chain
	import deq_pkg::*;
(
	input  logic                  clk,
	input  chain_req_t            req,
	input  logic [COUNT_BITS-1:0] count,
	output value_t                head
);

	value_t cell_val [CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		value_t left_v;
		value_t right_v;
		logic   tail_hit;

		if (i == 0) begin : g_first
			assign left_v = req.value;
		end else begin : g_mid
			assign left_v = cell_val[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_v = cell_val[i];
		end else begin : g_inner
			assign right_v = cell_val[i+1];
		end

		assign tail_hit = (count == COUNT_BITS'(i));

		deq_cell u_cell (
			.clk       (clk),
			.req       (req),
			.at_tail   (tail_hit),
			.left_val  (left_v),
			.right_val (right_v),
			.val       (cell_val[i])
		);
	end

	assign head = cell_val[0];

endmodule

>>> rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Results are registered: a result appears in the cycle after its request is accepted.
// Throughput: one request per cycle while a held result is taken (out_ready); all cells move together.
// Reset: arst_n clears the entry count and the output valid; cell contents
// are left as they are and are never read before being written.
//
// Fixed-capacity deque built from two chains of cells. The front chain keeps
// the front entry in cell 0, the rear chain keeps the back entry in cell 0,
// so both ends are always at a fixed place and no wide read mux is needed.
// Each request moves both chains in step:
//   push front : front chain inserts at head, rear chain appends at tail
//   push back  : front chain appends at tail, rear chain inserts at head
//   pop front  : front chain shifts out its head, rear chain only loses count
//   pop back   : rear chain shifts out its head, front chain only loses count
// Stale cells beyond the count are never read.
// ----------------------------------------------------------------------------
module double_ended_queue
	import deq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            op,
	input  logic [VALUE_BITS-1:0] push_value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            status,
	output logic [VALUE_BITS-1:0] popped_value,
	output logic [COUNT_BITS-1:0] entry_count
);

	logic [COUNT_BITS-1:0] count_q;
	logic                  out_valid_q;
	logic [1:0]            status_q;
	value_t                popped_q;
	logic [COUNT_BITS-1:0] entry_count_q;

	logic       accept;
	logic       full;
	logic       empty;
	logic       push_ok;
	logic       pop_ok;
	logic [1:0] status_d;
	value_t     popped_d;
	logic [COUNT_BITS-1:0] count_d;

	chain_req_t front_req;
	chain_req_t rear_req;
	value_t     front_head;
	value_t     rear_head;

	// output register frees the input side whenever the held result moves on
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	assign full  = (count_q == COUNT_BITS'(CAPACITY));
	assign empty = (count_q == '0);

	always_comb begin
		push_ok         = 1'b0;
		pop_ok          = 1'b0;
		status_d        = ST_OK;
		popped_d        = '0;
		front_req.mode  = MODE_HOLD;
		rear_req.mode   = MODE_HOLD;
		front_req.value = push_value;
		rear_req.value  = push_value;

		case (op)
			OP_PUSH_FRONT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					push_ok        = 1'b1;
					front_req.mode = MODE_INSERT;
					rear_req.mode  = MODE_APPEND;
				end
			end
			OP_PUSH_BACK: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					push_ok        = 1'b1;
					front_req.mode = MODE_APPEND;
					rear_req.mode  = MODE_INSERT;
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					pop_ok         = 1'b1;
					popped_d       = front_head;
					front_req.mode = MODE_REMOVE;
				end
			end
			default: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					pop_ok        = 1'b1;
					popped_d      = rear_head;
					rear_req.mode = MODE_REMOVE;
				end
			end
		endcase

		// chains move only on an accepted request
		if (!accept) begin
			front_req.mode = MODE_HOLD;
			rear_req.mode  = MODE_HOLD;
		end

		count_d = count_q;
		if (push_ok) begin
			count_d = count_q + COUNT_BITS'(1);
		end else if (pop_ok) begin
			count_d = count_q - COUNT_BITS'(1);
		end
	end

	deq_chain u_front (
		.clk   (clk),
		.req   (front_req),
		.count (count_q),
		.head  (front_head)
	);

	deq_chain u_rear (
		.clk   (clk),
		.req   (rear_req),
		.count (count_q),
		.head  (rear_head)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q      <= status_d;
			popped_q      <= popped_d;
			entry_count_q <= count_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign popped_value = popped_q;
	assign entry_count  = entry_count_q;

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the double-ended queue. Requests go in through a
// valid/ready driver fed from a pending list; every accepted request is run
// through a behavioral deque model and the result it owes is queued. A monitor
// checks each returned result in order, field by field. Stimulus covers the
// empty and full refusals, index wrap at both ends, a full fill and drain,
// and random mixes, with random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
	import deq_pkg::*;

	localparam int IDLE_PCT    = 10;      // idle cycles per hundred, each side
	localparam int CYCLE_LIMIT = 200000;  // far beyond the slowest legal run
	localparam int PRINT_LIMIT = 40;      // cap on mismatch lines

	// one request as the driver presents it
	typedef struct {
		logic [1:0] code;
		value_t     value;
		bit         drain_first;  // hold off until nothing is outstanding
		bit         quiet;        // no random idling while this one is active
	} deque_req_t;

	// one result as the block should return it
	typedef struct {
		logic [1:0]            status;
		value_t                popped;
		logic [COUNT_BITS-1:0] count;
	} deque_result_t;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  in_valid   = 1'b0;
	logic                  in_ready;
	logic [1:0]            op         = OP_PUSH_FRONT;
	logic [VALUE_BITS-1:0] push_value = '0;
	logic                  out_valid;
	logic                  out_ready  = 1'b0;
	logic [1:0]            status;
	logic [VALUE_BITS-1:0] popped_value;
	logic [COUNT_BITS-1:0] entry_count;

	deque_req_t    pending_q[$];   // requests not yet presented
	deque_result_t owed_q[$];      // results owed by the block, oldest first
	int            outstanding = 0; // registered copy of owed_q size
	bit            quiet_mode  = 1'b0;
	int            error_count = 0;
	int            cycle_count = 0;

	// model state: circular buffer with a front index and an entry count
	value_t slot_model[CAPACITY];
	int     front_model = 0;
	int     held_model  = 0;

	// run statistics
	int n_push_ok   = 0;
	int n_pop_ok    = 0;
	int n_full      = 0;
	int n_empty     = 0;
	int peak_count  = 0;

	double_ended_queue u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.push_value   (push_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.popped_value (popped_value),
		.entry_count  (entry_count)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------------
	// Deque model: applies one request and returns the result it causes.
	// Refused requests (push on full, pop on empty) leave the state alone.
	// ------------------------------------------------------------------------
	function automatic deque_result_t predict_deque(input logic [1:0] code,
	                                                input value_t value);
		deque_result_t r;
		int            slot;
		r.status = ST_OK;
		r.popped = '0;
		case (code)
			OP_PUSH_FRONT: begin
				if (held_model >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					front_model = (front_model + CAPACITY - 1) % CAPACITY;
					slot_model[front_model] = value;
					held_model++;
				end
			end
			OP_PUSH_BACK: begin
				if (held_model >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					slot = (front_model + held_model) % CAPACITY;
					slot_model[slot] = value;
					held_model++;
				end
			end
			OP_POP_FRONT: begin
				if (held_model == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.popped = slot_model[front_model];
					front_model = (front_model + 1) % CAPACITY;
					held_model--;
				end
			end
			default: begin
				if (held_model == 0) begin
					r.status = ST_EMPTY;
				end else begin
					slot = (front_model + held_model - 1) % CAPACITY;
					r.popped = slot_model[slot];
					held_model--;
				end
			end
		endcase
		r.count = held_model[COUNT_BITS-1:0];

		if (r.status == ST_FULL)
			n_full++;
		else if (r.status == ST_EMPTY)
			n_empty++;
		else if (code == OP_PUSH_FRONT || code == OP_PUSH_BACK)
			n_push_ok++;
		else
			n_pop_ok++;
		if (held_model > peak_count)
			peak_count = held_model;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
	                               input logic [31:0] want);
		if (error_count < PRINT_LIMIT)
			$display("MISMATCH %s: got %h, expected %h (cycle %0d)",
			         what, got, want, cycle_count);
		error_count++;
	endtask

	task automatic add_req(input logic [1:0] code, input value_t value,
	                       input bit drain_first, input bit quiet);
		deque_req_t r;
		r.code        = code;
		r.value       = value;
		r.drain_first = drain_first;
		r.quiet       = quiet;
		pending_q.push_back(r);
	endtask

	// random value, leaning on the all-zero and all-one corners now and then
	function automatic value_t rand_value();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Request driver. A new request is loaded only when the current one has
	// been taken (or none is up), so valid and payload hold while stalled.
	// At most one assignment to in_valid per edge.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : request_driver
		deque_req_t nxt;
		if (!arst_n) begin
			in_valid   <= 1'b0;
			op         <= OP_PUSH_FRONT;
			push_value <= '0;
			quiet_mode <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (pending_q.size() == 0) begin
				in_valid <= 1'b0;
			end else begin
				nxt = pending_q[0];
				if (nxt.drain_first && (in_valid || outstanding != 0)) begin
					// pause until every owed result is back
					in_valid <= 1'b0;
				end else if (!nxt.quiet && $urandom_range(99) < IDLE_PCT) begin
					in_valid <= 1'b0;
				end else begin
					void'(pending_q.pop_front());
					in_valid   <= 1'b1;
					op         <= nxt.code;
					push_value <= nxt.value;
					quiet_mode <= nxt.quiet;
				end
			end
		end
	end

	// result-side back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= quiet_mode || ($urandom_range(99) >= IDLE_PCT);
	end

	// ------------------------------------------------------------------------
	// Monitor. Captures accepted requests into the model first, then checks
	// an accepted result against the oldest owed one, so the order of the
	// two handshakes within an edge does not matter.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : result_monitor
		deque_result_t want;
		if (!arst_n) begin
			outstanding <= 0;
		end else begin
			if (in_valid && in_ready)
				owed_q.push_back(predict_deque(op, push_value));
			if (out_valid && out_ready) begin
				if (owed_q.size() == 0) begin
					report_mismatch("unexpected result", {30'd0, status}, 32'd0);
				end else begin
					want = owed_q.pop_front();
					if (status !== want.status)
						report_mismatch("status", {30'd0, status}, {30'd0, want.status});
					if (popped_value !== want.popped)
						report_mismatch("popped_value", popped_value, want.popped);
					if (entry_count !== want.count)
						report_mismatch("entry_count", 32'(entry_count), 32'(want.count));
				end
			end
			outstanding <= owed_q.size();
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Some tests failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin : stimulus
		int         push_pct;
		logic [1:0] code;

		// directed: empty pops, value extremes, wrap of the front index below
		// slot zero, both pop ends, then back to empty
		add_req(OP_POP_FRONT,  32'h0000_0000, 1'b0, 1'b0);
		add_req(OP_POP_BACK,   32'hFFFF_FFFF, 1'b0, 1'b0);
		add_req(OP_PUSH_FRONT, 32'h0000_0000, 1'b0, 1'b0);
		add_req(OP_PUSH_BACK,  32'hFFFF_FFFF, 1'b0, 1'b0);
		add_req(OP_PUSH_FRONT, 32'h5555_5555, 1'b0, 1'b0);
		add_req(OP_PUSH_BACK,  32'hAAAA_AAAA, 1'b0, 1'b0);
		add_req(OP_POP_FRONT,  32'h1234_5678, 1'b0, 1'b0);
		add_req(OP_POP_BACK,   32'h0000_0000, 1'b0, 1'b0);
		add_req(OP_POP_BACK,   32'h0000_0000, 1'b0, 1'b0);
		add_req(OP_POP_FRONT,  32'h0000_0000, 1'b0, 1'b0);
		add_req(OP_POP_BACK,   32'h0000_0000, 1'b0, 1'b0);
		add_req(OP_PUSH_BACK,  32'h0000_0001, 1'b0, 1'b0);
		add_req(OP_PUSH_BACK,  32'h8000_0000, 1'b0, 1'b0);
		add_req(OP_POP_FRONT,  32'h0000_0000, 1'b0, 1'b0);
		add_req(OP_PUSH_FRONT, 32'h1234_5678, 1'b0, 1'b0);
		add_req(OP_POP_BACK,   32'h0000_0000, 1'b0, 1'b0);
		add_req(OP_POP_FRONT,  32'h0000_0000, 1'b0, 1'b0);
		add_req(OP_POP_FRONT,  32'h0000_0000, 1'b0, 1'b0);

		// fill to capacity and past it, back to back with no idling on
		// either side; starts from a fully drained block
		for (int i = 0; i < CAPACITY + 6; i++)
			add_req($urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT, rand_value(),
			        i == 0, 1'b1);
		add_req(OP_PUSH_FRONT, 32'hDEAD_BEEF, 1'b0, 1'b1);
		add_req(OP_PUSH_BACK,  32'hDEAD_BEEF, 1'b0, 1'b1);

		// drain from both ends and past empty, with random stalls
		for (int i = 0; i < CAPACITY + 6; i++)
			add_req($urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT, rand_value(),
			        1'b0, 1'b0);
		add_req(OP_POP_FRONT, 32'h0000_0000, 1'b0, 1'b0);
		add_req(OP_POP_BACK,  32'h0000_0000, 1'b0, 1'b0);

		// random segments with varying push/pop balance
		for (int seg = 0; seg < 10; seg++) begin
			case ($urandom_range(2))
				0:       push_pct = 25;
				1:       push_pct = 50;
				default: push_pct = 80;
			endcase
			for (int i = 0; i < 40; i++) begin
				if ($urandom_range(99) < push_pct)
					code = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
				else
					code = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
				add_req(code, rand_value(), seg == 5 && i == 0, seg == 3);
			end
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait for every request to go in and every result to come back
		while (pending_q.size() != 0 || in_valid || owed_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (owed_q.size() != 0)
			report_mismatch("results missing", owed_q.size(), 32'd0);

		$display("Covered %0d pushes, %0d pops, %0d refused on full, %0d refused on empty",
		         n_push_ok, n_pop_ok, n_full, n_empty);
		$display("Peak occupancy %0d of %0d, %0d mismatches, %0d cycles",
		         peak_count, CAPACITY, error_count, cycle_count);
		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
